/* hw/rtl/erw_pkg.sv */
package erw_pkg;

   typedef enum logic [2:0] {
      ACT_STAGE  = 3'd0,
      ACT_COMMIT = 3'd1,
      ACT_TICK   = 3'd2,
      ACT_READ   = 3'd3,
      ACT_VERIFY = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_INDEX = 2'd1,
      ST_BUSY  = 2'd2
   } status_type;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic walk_step;
      logic fetch;
      logic apply;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic walk_last;
   } sts_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  read_data;
      logic        write_strobe;
      logic [7:0]  write_addr;
      logic [7:0]  write_data;
      logic        writer_active;
      logic [7:0]  bytes_done;
      logic        checksum_valid;
   } result_type;

endpackage

/* hw/rtl/erw_ctl.sv */
module erw_ctl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_action,
   input  erw_pkg::sts_type sts,
   input  logic             out_free,
   output erw_pkg::cmd_type cmd
);
   import erw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_TAIL,
      S_FETCH,
      S_REPLY
   } state_type;

   state_type state_ff;
   logic      accept;
   logic      is_walk;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign is_walk   = (req_action == ACT_COMMIT) || (req_action == ACT_VERIFY);

   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.walk_step = (state_ff == S_WALK);
      cmd.fetch     = (state_ff == S_FETCH);
      cmd.apply     = (state_ff == S_REPLY) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= is_walk ? S_WALK : S_FETCH;
               end
            end
            S_WALK: begin
               if (sts.walk_last) begin
                  state_ff <= S_TAIL;
               end
            end
            S_TAIL:  state_ff <= S_REPLY;
            S_FETCH: state_ff <= S_REPLY;
            S_REPLY: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/erw_dp.sv */
module erw_dp #(
   parameter int RECORD_BYTES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  erw_pkg::cmd_type    cmd,
   output erw_pkg::sts_type    sts,
   input  logic [2:0]          req_action,
   input  logic [7:0]          req_index,
   input  logic [7:0]          req_value,
   input  logic                req_nvm_busy,
   output erw_pkg::result_type res
);
   import erw_pkg::*;

   localparam int SL   = RECORD_BYTES + 2;
   localparam int RA_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
   localparam int SA_W = $clog2(SL);
   localparam int PW   = $clog2(SL + 1);

   // Captured item.
   logic [2:0]  act_ff;
   logic [7:0]  idx_ff;
   logic [7:0]  val_ff;
   logic        busy_ff;

   // Architectural state.
   logic [15:0]   cks_ff;
   logic [PW-1:0] ptr_ff;
   logic          armed_ff;

   // Walk and accumulation.
   logic [SA_W-1:0] cnt_ff;
   logic [SA_W-1:0] tag_ff;
   logic            pend_ff;
   logic [15:0]     acc_ff;
   logic [7:0]      lo_ff;
   logic [7:0]      hi_ff;

   // Memories with per-entry valid bits standing in for the reset values.
   logic [7:0]      stg_mem_ff [RECORD_BYTES];
   logic [RECORD_BYTES-1:0] stg_vld_ff;
   logic [7:0]      sto_mem_ff [SL];
   logic [SL-1:0]   sto_vld_ff;
   logic [7:0]      stg_q_ff;
   logic            stg_qv_ff;
   logic [7:0]      sto_q_ff;
   logic            sto_qv_ff;

   logic [RA_W-1:0] stg_ra;
   logic [SA_W-1:0] sto_ra;
   logic            rd_en;
   logic [7:0]      stg_rd;
   logic [7:0]      sto_rd;
   logic            is_commit;

   logic            stg_we;
   logic            sto_we;
   logic [7:0]      want;
   logic [15:0]     cks_in;
   logic [PW-1:0]   ptr_in;
   logic            armed_in;

   assign is_commit = (act_ff == ACT_COMMIT);
   assign rd_en     = cmd.walk_step || cmd.fetch;
   assign stg_rd    = stg_qv_ff ? stg_q_ff : 8'h00;
   assign sto_rd    = sto_qv_ff ? sto_q_ff : ERASED_BYTE;

   always_comb begin
      sts = '0;
      if (is_commit) begin
         sts.walk_last = (cnt_ff == SA_W'(RECORD_BYTES - 1));
      end else begin
         sts.walk_last = (cnt_ff == SA_W'(SL - 1));
      end
   end

   always_comb begin
      stg_ra = '0;
      sto_ra = '0;
      if (cmd.walk_step) begin
         if (is_commit) begin
            stg_ra = cnt_ff[RA_W-1:0];
         end
         sto_ra = cnt_ff;
      end else if (act_ff == ACT_READ) begin
         if (idx_ff < 8'(SL)) begin
            sto_ra = idx_ff[SA_W-1:0];
         end
      end else begin
         if (ptr_ff < PW'(RECORD_BYTES)) begin
            stg_ra = ptr_ff[RA_W-1:0];
         end
         if (ptr_ff < PW'(SL)) begin
            sto_ra = ptr_ff[SA_W-1:0];
         end
      end
   end

   // Byte the writer wants at the current pointer.
   always_comb begin
      if (ptr_ff < PW'(RECORD_BYTES)) begin
         want = stg_rd;
      end else if (ptr_ff == PW'(RECORD_BYTES)) begin
         want = cks_ff[7:0];
      end else begin
         want = cks_ff[15:8];
      end
   end

   always_comb begin
      res            = '0;
      stg_we         = 1'b0;
      sto_we         = 1'b0;
      cks_in         = cks_ff;
      ptr_in         = ptr_ff;
      armed_in       = armed_ff;
      unique case (act_ff)
         ACT_STAGE: begin
            if (idx_ff < 8'(RECORD_BYTES)) begin
               stg_we = 1'b1;
            end else begin
               res.status = ST_INDEX;
            end
         end
         ACT_COMMIT: begin
            cks_in   = acc_ff;
            ptr_in   = '0;
            armed_in = 1'b1;
         end
         ACT_TICK: begin
            if (armed_ff) begin
               if (ptr_ff < PW'(SL)) begin
                  if (sto_rd == want) begin
                     ptr_in = ptr_ff + PW'(1);
                  end else if (busy_ff) begin
                     res.status = ST_BUSY;
                  end else begin
                     sto_we           = 1'b1;
                     res.write_strobe = 1'b1;
                     res.write_addr   = 8'(ptr_ff);
                     res.write_data   = want;
                     ptr_in           = ptr_ff + PW'(1);
                  end
               end else begin
                  armed_in = 1'b0;
               end
            end
         end
         ACT_READ: begin
            if (idx_ff < 8'(SL)) begin
               res.read_data = sto_rd;
            end else begin
               res.status = ST_INDEX;
            end
         end
         ACT_VERIFY: begin
            res.checksum_valid = (acc_ff == {hi_ff, lo_ff});
         end
         default: begin
         end
      endcase
      res.writer_active = armed_in;
      res.bytes_done    = 8'(ptr_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         idx_ff  <= req_index;
         val_ff  <= req_value;
         busy_ff <= req_nvm_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cks_ff   <= '0;
         ptr_ff   <= '0;
         armed_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.walk_step;
         if (cmd.apply) begin
            cks_ff   <= cks_in;
            ptr_ff   <= ptr_in;
            armed_ff <= armed_in;
         end
      end
   end

   // The walk reads one byte per cycle; each byte is folded in the cycle after its read.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cnt_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (cmd.walk_step) begin
            cnt_ff <= cnt_ff + SA_W'(1);
            tag_ff <= cnt_ff;
         end
         if (pend_ff) begin
            if (is_commit) begin
               acc_ff <= acc_ff + 16'(stg_rd);
            end else if (tag_ff < SA_W'(RECORD_BYTES)) begin
               acc_ff <= acc_ff + 16'(sto_rd);
            end else if (tag_ff == SA_W'(RECORD_BYTES)) begin
               lo_ff <= sto_rd;
            end else begin
               hi_ff <= sto_rd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && stg_we) begin
         stg_mem_ff[idx_ff[RA_W-1:0]] <= val_ff;
      end
      if (rd_en) begin
         stg_q_ff  <= stg_mem_ff[stg_ra];
         stg_qv_ff <= stg_vld_ff[stg_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && sto_we) begin
         sto_mem_ff[ptr_ff[SA_W-1:0]] <= want;
      end
      if (rd_en) begin
         sto_q_ff  <= sto_mem_ff[sto_ra];
         sto_qv_ff <= sto_vld_ff[sto_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
         sto_vld_ff <= '0;
      end else if (cmd.apply) begin
         if (stg_we) begin
            stg_vld_ff[idx_ff[RA_W-1:0]] <= 1'b1;
         end
         if (sto_we) begin
            sto_vld_ff[ptr_ff[SA_W-1:0]] <= 1'b1;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PW'(SL))
      else $error("write pointer beyond end of store");

   a_write_armed: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && sto_we |-> armed_ff && (act_ff == ACT_TICK) && !busy_ff)
      else $error("store written outside an armed, non-busy tick");

   a_write_differs: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && sto_we |-> (sto_rd != want))
      else $error("store written with a byte it already holds");

   a_commit_arms: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && (act_ff == ACT_COMMIT) |=> armed_ff && (ptr_ff == '0))
      else $error("commit did not arm the writer at position zero");
`endif

endmodule

/* hw/rtl/eeprom_record_writeback.sv */
// Stage, tick, read and unused codes pass through the fetch state to the reply state.
// Commit walks the staged record and verify walks the store with its checksum bytes, one byte per
// cycle through the single read port of the staged record or the store.
// One item is in work at a time; the next transfer is taken once the result has been
// loaded into the output register.
// Synchronous reset: record reads as zero and store as erased 0xFF at once.
module eeprom_record_writeback #(
   parameter int RECORD_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_index,
   input  logic [7:0] req_value,
   input  logic       req_nvm_busy,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_read_data,
   output logic       rsp_write_strobe,
   output logic [7:0] rsp_write_addr,
   output logic [7:0] rsp_write_data,
   output logic       rsp_writer_active,
   output logic [7:0] rsp_bytes_done,
   output logic       rsp_checksum_valid
);
   import erw_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   result_type res;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   erw_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .sts        (sts),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   erw_dp #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_action   (req_action),
      .req_index    (req_index),
      .req_value    (req_value),
      .req_nvm_busy (req_nvm_busy),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_read_data      = rsp_ff.read_data;
   assign rsp_write_strobe   = rsp_ff.write_strobe;
   assign rsp_write_addr     = rsp_ff.write_addr;
   assign rsp_write_data     = rsp_ff.write_data;
   assign rsp_writer_active  = rsp_ff.writer_active;
   assign rsp_bytes_done     = rsp_ff.bytes_done;
   assign rsp_checksum_valid = rsp_ff.checksum_valid;

endmodule
